// ===== hw/rtl/tii_pkg.sv =====
package tii_pkg;

    localparam int COORD_W = 32;
    localparam int VALUE_W = 32;
    localparam int FRAC_W = 17;
    localparam int ADDR_W = 17;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int CFG_INDEX_W = 3;
    localparam int IN_DATA_W = 152;

    localparam int DEF_N_RHO = 64;
    localparam int DEF_N_TEMP = 64;
    localparam int DEF_N_YE = 32;
    localparam int DEF_VALUE_BITS = 32;

    localparam logic [FRAC_W-1:0] ONE_FRAC = 17'h10000;

    localparam logic MODE_QUERY = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_DENSITY_MIN = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DENSITY_INV_STEP = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_MIN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_INV_STEP = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAC_MIN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAC_INV_STEP = 3'd5;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [FRAC_W-1:0] frac_t;

endpackage

// ===== hw/rtl/trilinear_table_interpolator_core.sv =====
// Trilinear interpolator over a table held on a uniform three-axis grid.
// Items arrive on the s_axis channel; tuser selects a query (0) or an entry
// write (1). A write stores entry_value at entry_address and gives no result.
// A query returns the interpolated value on m_axis_tdata and the per-axis
// clamp flags on m_axis_tuser, in the order the queries were accepted.
// The cfg channel writes the grid minimum and reciprocal step of each axis;
// it is always ready and should be used only while the block is idle.
// One item is accepted every cycle while the output is not stalled. The
// pipeline is three stages of axis location, one stage of table read from
// eight copies of the table (one per cell corner, all written together) and
// three blend stages ahead of the output register.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready falls, so no request is lost or repeated.
// Reset clears the valid bits and restores the configuration defaults; the
// table contents are undefined until written.
module trilinear_table_interpolator_core
    import tii_pkg::*;
#(
    parameter int N_RHO = DEF_N_RHO,
    parameter int N_TEMP = DEF_N_TEMP,
    parameter int N_YE = DEF_N_YE,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // density_coord, temp_coord, frac_coord, entry_address, entry_value, zero pad
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // mode
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // interp_value
    output logic [VALUE_W-1:0]     m_axis_tdata,
    // clamp_flags
    output logic [2:0]             m_axis_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]     cfg_data
);

    localparam int RW = $clog2(N_RHO);
    localparam int TW = $clog2(N_TEMP);
    localparam int YW = $clog2(N_YE);
    localparam int SAT_BITS = VALUE_BITS < 32 ? VALUE_BITS : 32;
    localparam logic signed [VALUE_W-1:0] SAT_HI = VALUE_W'((64'sd1 <<< (SAT_BITS - 1)) - 1);
    localparam logic signed [VALUE_W-1:0] SAT_LO = VALUE_W'(-(64'sd1 <<< (SAT_BITS - 1)));

    logic [COORD_W-1:0] density_min_reg;
    logic [COORD_W-1:0] density_inv_step_reg;
    logic [COORD_W-1:0] temp_min_reg;
    logic [COORD_W-1:0] temp_inv_step_reg;
    logic [COORD_W-1:0] frac_min_reg;
    logic [COORD_W-1:0] frac_inv_step_reg;

    logic en;
    logic [7:1] valid_reg;
    logic       mode1_reg, mode2_reg, mode3_reg;
    logic [ADDR_W-1:0] waddr1_reg, waddr2_reg, waddr3_reg;
    value_t     wval1_reg, wval2_reg, wval3_reg;

    logic [RW-1:0] ir;
    logic [TW-1:0] it;
    logic [YW-1:0] iy;
    frac_t fr, ft, fy;
    logic [2:0] clamp3;
    frac_t fr4_reg, ft4_reg, fy4_reg, ft5_reg, fy5_reg, fy6_reg;
    logic [2:0] flags4_reg, flags5_reg, flags6_reg, flags7_reg;

    logic [ADDR_W-1:0] corner_addr [8];
    value_t corner_val [8];
    value_t c00, c10, c01, c11, c0, c1, blend_v;

    logic m_valid_reg;
    value_t m_data_reg;
    logic [2:0] m_flags_reg;
    value_t sat_next;

    assign en = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            density_min_reg <= '0;
            density_inv_step_reg <= 32'd65536;
            temp_min_reg <= '0;
            temp_inv_step_reg <= 32'd65536;
            frac_min_reg <= '0;
            frac_inv_step_reg <= 32'd65536;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DENSITY_MIN:      density_min_reg <= cfg_data;
                CFG_DENSITY_INV_STEP: density_inv_step_reg <= cfg_data;
                CFG_TEMP_MIN:         temp_min_reg <= cfg_data;
                CFG_TEMP_INV_STEP:    temp_inv_step_reg <= cfg_data;
                CFG_FRAC_MIN:         frac_min_reg <= cfg_data;
                CFG_FRAC_INV_STEP:    frac_inv_step_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    tii_axis #(.N(N_RHO)) u_axis_rho (
        .clk(clk), .en(en), .coord(s_axis_tdata[31:0]),
        .min_val(density_min_reg), .inv_step(density_inv_step_reg),
        .idx(ir), .frac(fr), .clamped(clamp3[0])
    );

    tii_axis #(.N(N_TEMP)) u_axis_temp (
        .clk(clk), .en(en), .coord(s_axis_tdata[63:32]),
        .min_val(temp_min_reg), .inv_step(temp_inv_step_reg),
        .idx(it), .frac(ft), .clamped(clamp3[1])
    );

    tii_axis #(.N(N_YE)) u_axis_ye (
        .clk(clk), .en(en), .coord(s_axis_tdata[95:64]),
        .min_val(frac_min_reg), .inv_step(frac_inv_step_reg),
        .idx(iy), .frac(fy), .clamped(clamp3[2])
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[1] <= s_axis_tvalid;
            valid_reg[2] <= valid_reg[1];
            valid_reg[3] <= valid_reg[2];
            valid_reg[4] <= valid_reg[3] && (mode3_reg == MODE_QUERY);
            valid_reg[5] <= valid_reg[4];
            valid_reg[6] <= valid_reg[5];
            valid_reg[7] <= valid_reg[6];
            m_valid_reg <= valid_reg[7];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode1_reg <= s_axis_tuser;
            waddr1_reg <= s_axis_tdata[112:96];
            wval1_reg <= s_axis_tdata[144:113];
            mode2_reg <= mode1_reg;
            waddr2_reg <= waddr1_reg;
            wval2_reg <= wval1_reg;
            mode3_reg <= mode2_reg;
            waddr3_reg <= waddr2_reg;
            wval3_reg <= wval2_reg;
            fr4_reg <= fr;
            ft4_reg <= ft;
            fy4_reg <= fy;
            flags4_reg <= clamp3;
            ft5_reg <= ft4_reg;
            fy5_reg <= fy4_reg;
            flags5_reg <= flags4_reg;
            fy6_reg <= fy5_reg;
            flags6_reg <= flags5_reg;
            flags7_reg <= flags6_reg;
            m_data_reg <= sat_next;
            m_flags_reg <= flags7_reg;
        end
    end

    always_comb
    begin
        logic [31:0] r0, r1, t0, t1, y0, y1;
        r0 = 32'(ir);
        r1 = 32'(ir) + 32'd1;
        t0 = 32'(it);
        t1 = 32'(it) + 32'd1;
        y0 = 32'(iy);
        y1 = 32'(iy) + 32'd1;
        for (int k = 0; k < 8; k++)
        begin
            logic [31:0] a;
            a = (k[0] ? r1 : r0) + 32'(N_RHO) *
                ((k[1] ? t1 : t0) + 32'(N_TEMP) * (k[2] ? y1 : y0));
            corner_addr[k] = a[ADDR_W-1:0];
        end
    end

    for (genvar g = 0; g < 8; g++)
    begin : g_bank
        tii_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_DEPTH)) u_ram (
            .clk(clk),
            .we(en && valid_reg[3] && (mode3_reg == MODE_WRITE)),
            .waddr(waddr3_reg),
            .wdata(wval3_reg),
            .re(en),
            .raddr(corner_addr[g]),
            .rdata(corner_val[g])
        );
    end

    tii_lerp u_l00 (.clk(clk), .en(en), .a(corner_val[0]), .b(corner_val[1]),
                    .f(fr4_reg), .q(c00));
    tii_lerp u_l10 (.clk(clk), .en(en), .a(corner_val[2]), .b(corner_val[3]),
                    .f(fr4_reg), .q(c10));
    tii_lerp u_l01 (.clk(clk), .en(en), .a(corner_val[4]), .b(corner_val[5]),
                    .f(fr4_reg), .q(c01));
    tii_lerp u_l11 (.clk(clk), .en(en), .a(corner_val[6]), .b(corner_val[7]),
                    .f(fr4_reg), .q(c11));
    tii_lerp u_l0 (.clk(clk), .en(en), .a(c00), .b(c10), .f(ft5_reg), .q(c0));
    tii_lerp u_l1 (.clk(clk), .en(en), .a(c01), .b(c11), .f(ft5_reg), .q(c1));
    tii_lerp u_lv (.clk(clk), .en(en), .a(c0), .b(c1), .f(fy6_reg), .q(blend_v));

    always_comb
    begin
        if ($signed(blend_v) > SAT_HI)
        begin
            sat_next = SAT_HI;
        end
        else if ($signed(blend_v) < SAT_LO)
        begin
            sat_next = SAT_LO;
        end
        else
        begin
            sat_next = blend_v;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata = m_data_reg;
    assign m_axis_tuser = m_flags_reg;

endmodule

// ===== hw/rtl/tii_ram.sv =====
module tii_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tii_axis.sv =====
module tii_axis
    import tii_pkg::*;
#(
    parameter int N = DEF_N_RHO
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [COORD_W-1:0]     coord,
    input  logic [COORD_W-1:0]     min_val,
    input  logic [COORD_W-1:0]     inv_step,
    output logic [$clog2(N)-1:0]   idx,
    output frac_t                  frac,
    output logic                   clamped
);

    localparam int IDX_W = $clog2(N);
    localparam logic [COORD_W-1:0] LAST_CELL = COORD_W'(N - 1);
    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(N - 2);

    logic [COORD_W:0]     diff_next;
    logic [COORD_W-1:0]   mag_reg;
    logic                 neg1_reg;
    logic [COORD_W-1:0]   inv1_reg;
    logic [2*COORD_W-1:0] prod_reg;
    logic                 neg2_reg;
    logic                 inv_nz2_reg;
    logic [IDX_W-1:0]     idx_next;
    frac_t                frac_next;
    logic                 clamp_next;
    logic [IDX_W-1:0]     idx_reg;
    frac_t                frac_reg;
    logic                 clamp_reg;

    assign diff_next = {coord[COORD_W-1], coord} - {min_val[COORD_W-1], min_val};

    always_comb
    begin
        if (neg2_reg)
        begin
            idx_next = '0;
            frac_next = '0;
            clamp_next = inv_nz2_reg;
        end
        else if (prod_reg[2*COORD_W-1:COORD_W] >= LAST_CELL)
        begin
            idx_next = TOP_IDX;
            frac_next = ONE_FRAC;
            clamp_next = 1'b1;
        end
        else
        begin
            idx_next = prod_reg[COORD_W+IDX_W-1:COORD_W];
            frac_next = {1'b0, prod_reg[COORD_W-1:COORD_W-16]};
            clamp_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= diff_next[COORD_W-1:0];
            neg1_reg <= diff_next[COORD_W];
            inv1_reg <= inv_step;
            prod_reg <= mag_reg * inv1_reg;
            neg2_reg <= neg1_reg;
            inv_nz2_reg <= (inv1_reg != '0);
            idx_reg <= idx_next;
            frac_reg <= frac_next;
            clamp_reg <= clamp_next;
        end
    end

    assign idx = idx_reg;
    assign frac = frac_reg;
    assign clamped = clamp_reg;

endmodule

// ===== hw/rtl/tii_lerp.sv =====
module tii_lerp
    import tii_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  value_t a,
    input  value_t b,
    input  frac_t  f,
    output value_t q
);

    logic signed [49:0] prod_a;
    logic signed [49:0] prod_b;
    logic signed [49:0] sum;
    frac_t              wa;
    value_t             q_reg;

    always_comb
    begin
        wa = ONE_FRAC - f;
        prod_a = $signed(a) * $signed({1'b0, wa});
        prod_b = $signed(b) * $signed({1'b0, f});
        sum = prod_a + prod_b + 50'sd32768;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= sum[47:16];
        end
    end

    assign q = q_reg;

endmodule

// ===== test/tb_trilinear_table_interpolator_core.sv =====
class interp_scoreboard;
    localparam int N_RHO = 64;
    localparam int N_TEMP = 64;
    localparam int N_YE = 32;
    localparam int VALUE_BITS = 32;

    logic [31:0] cfg_regs [6];
    logic [31:0] entries [int];
    logic [31:0] value_fifo [$];
    logic [2:0]  flag_fifo [$];
    int          errors;

    function new();
        cfg_regs[tii_pkg::CFG_DENSITY_MIN] = 32'd0;
        cfg_regs[tii_pkg::CFG_DENSITY_INV_STEP] = 32'd65536;
        cfg_regs[tii_pkg::CFG_TEMP_MIN] = 32'd0;
        cfg_regs[tii_pkg::CFG_TEMP_INV_STEP] = 32'd65536;
        cfg_regs[tii_pkg::CFG_FRAC_MIN] = 32'd0;
        cfg_regs[tii_pkg::CFG_FRAC_INV_STEP] = 32'd65536;
        errors = 0;
    endfunction

    function bit locate(logic [31:0] coord, logic [31:0] minv, logic [31:0] inv, int n,
                        output int idx, output longint frac);
        longint    d;
        longint    m;
        bit [63:0] prod;
        d = $signed(coord);
        m = $signed(minv);
        d = d - m;
        if (d < 0)
        begin
            idx = 0;
            frac = 0;
            return inv != 0;
        end
        prod = 64'(d) * 64'(inv);
        if (prod[63:32] >= 64'(n - 1))
        begin
            idx = n - 2;
            frac = 65536;
            return 1'b1;
        end
        idx = int'(prod[63:32]);
        frac = longint'(prod[31:16]);
        return 1'b0;
    endfunction

    function int entry_addr(int ir, int it, int iy);
        return (ir + N_RHO * (it + N_TEMP * iy)) & (tii_pkg::STORE_DEPTH - 1);
    endfunction

    function longint entry_at(int ir, int it, int iy);
        logic [31:0] raw;
        longint      v;
        raw = entries.exists(entry_addr(ir, it, iy)) ? entries[entry_addr(ir, it, iy)] : 32'd0;
        v = $signed(raw);
        return v;
    endfunction

    function longint blend(longint a, longint b, longint f);
        return (a * (65536 - f) + b * f + 32768) >>> 16;
    endfunction

    function void note_request(logic mode, logic [31:0] dc, logic [31:0] tc, logic [31:0] fc,
                               logic [16:0] addr, logic [31:0] value);
        int     ir, it, iy;
        longint fr, ft, fy, c00, c10, c01, c11, c0, c1, v, hi, lo;
        logic [2:0] flags;
        if (mode == tii_pkg::MODE_WRITE)
        begin
            entries[int'(addr)] = value;
            return;
        end
        flags[0] = locate(dc, cfg_regs[tii_pkg::CFG_DENSITY_MIN],
                          cfg_regs[tii_pkg::CFG_DENSITY_INV_STEP], N_RHO, ir, fr);
        flags[1] = locate(tc, cfg_regs[tii_pkg::CFG_TEMP_MIN],
                          cfg_regs[tii_pkg::CFG_TEMP_INV_STEP], N_TEMP, it, ft);
        flags[2] = locate(fc, cfg_regs[tii_pkg::CFG_FRAC_MIN],
                          cfg_regs[tii_pkg::CFG_FRAC_INV_STEP], N_YE, iy, fy);
        c00 = blend(entry_at(ir, it, iy), entry_at(ir + 1, it, iy), fr);
        c10 = blend(entry_at(ir, it + 1, iy), entry_at(ir + 1, it + 1, iy), fr);
        c01 = blend(entry_at(ir, it, iy + 1), entry_at(ir + 1, it, iy + 1), fr);
        c11 = blend(entry_at(ir, it + 1, iy + 1), entry_at(ir + 1, it + 1, iy + 1), fr);
        c0 = blend(c00, c10, ft);
        c1 = blend(c01, c11, ft);
        v = blend(c0, c1, fy);
        hi = (longint'(1) << ((VALUE_BITS < 32 ? VALUE_BITS : 32) - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        value_fifo.push_back(v[31:0]);
        flag_fifo.push_back(flags);
    endfunction

    function void check_result(logic [31:0] value, logic [2:0] flags);
        logic [31:0] exp_value;
        logic [2:0]  exp_flags;
        if (value_fifo.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: value %h flags %b", value, flags);
            return;
        end
        exp_value = value_fifo.pop_front();
        exp_flags = flag_fifo.pop_front();
        if (value !== exp_value || flags !== exp_flags)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: value exp %h got %h, flags exp %b got %b",
                         exp_value, value, exp_flags, flags);
        end
    endfunction
endclass

module tb_trilinear_table_interpolator_core;
    import tii_pkg::*;

    localparam int N_RHO = 64;
    localparam int N_TEMP = 64;
    localparam int N_YE = 32;
    localparam int CYCLE_LIMIT = 1000000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [VALUE_W-1:0]     m_axis_tdata;
    logic [2:0]             m_axis_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [COORD_W-1:0]     cfg_data;

    interp_scoreboard lookups;
    int cycle_count;
    int burst_left;
    int stall_kind;

    trilinear_table_interpolator_core #(
        .N_RHO(N_RHO),
        .N_TEMP(N_TEMP),
        .N_YE(N_YE),
        .VALUE_BITS(32)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver switches at random among four stall kinds.
    always @(negedge clk)
    begin
        if (cycle_count % 256 == 0)
            stall_kind = $urandom_range(0, 3);
        case (stall_kind)
            0: m_axis_tready = 1'b1;
            1: m_axis_tready = 1'($urandom_range(0, 1));
            2: m_axis_tready = ($urandom_range(0, 3) == 0);
            default: m_axis_tready = cycle_count[3];
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            lookups.check_result(m_axis_tdata, m_axis_tuser);
    end

    task automatic send_request(logic mode, logic [31:0] dc, logic [31:0] tc,
                                logic [31:0] fc, logic [16:0] addr, logic [31:0] value);
        int gap;
        if (burst_left == 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        else
            @(negedge clk);
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tuser = mode;
        s_axis_tdata = {7'd0, value, addr, fc, tc, dc};
        do
            @(posedge clk);
        while (!s_axis_tready);
        lookups.note_request(mode, dc, tc, fc, addr, value);
    endtask

    task automatic write_entry(int addr, logic [31:0] value);
        send_request(MODE_WRITE, $urandom, $urandom, $urandom, addr[16:0], value);
    endtask

    // Every corner that a query will read is written first.
    task automatic run_query(logic [31:0] dc, logic [31:0] tc, logic [31:0] fc);
        int     ir, it, iy, a;
        longint f;
        void'(lookups.locate(dc, lookups.cfg_regs[CFG_DENSITY_MIN],
                             lookups.cfg_regs[CFG_DENSITY_INV_STEP], N_RHO, ir, f));
        void'(lookups.locate(tc, lookups.cfg_regs[CFG_TEMP_MIN],
                             lookups.cfg_regs[CFG_TEMP_INV_STEP], N_TEMP, it, f));
        void'(lookups.locate(fc, lookups.cfg_regs[CFG_FRAC_MIN],
                             lookups.cfg_regs[CFG_FRAC_INV_STEP], N_YE, iy, f));
        for (int k = 0; k < 8; k++)
        begin
            a = lookups.entry_addr(ir + k[0], it + k[1], iy + k[2]);
            if (!lookups.entries.exists(a))
                write_entry(a, ($urandom_range(0, 1) == 0) ? $urandom
                                                           : $urandom_range(0, 2000000) - 1000000);
        end
        send_request(MODE_QUERY, dc, tc, fc, 17'($urandom), $urandom);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (lookups.value_fifo.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [31:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        lookups.cfg_regs[index] = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_grid(logic [31:0] dmin, logic [31:0] dinv, logic [31:0] tmin,
                             logic [31:0] tinv, logic [31:0] fmin, logic [31:0] finv);
        wait_idle();
        write_register(CFG_DENSITY_MIN, dmin);
        write_register(CFG_DENSITY_INV_STEP, dinv);
        write_register(CFG_TEMP_MIN, tmin);
        write_register(CFG_TEMP_INV_STEP, tinv);
        write_register(CFG_FRAC_MIN, fmin);
        write_register(CFG_FRAC_INV_STEP, finv);
    endtask

    function automatic logic [31:0] pick_coord(logic [31:0] minv, logic [31:0] inv, int n);
        longint pos;
        longint grid_step;
        if (inv == 0 || $urandom_range(0, 7) == 0)
            return $urandom;
        pos = longint'($urandom_range(0, (n + 3) * 65536)) - 2 * 65536;
        if ($urandom_range(0, 7) == 0)
            pos = longint'($urandom_range(0, n - 1)) * 65536;
        grid_step = 64'h1_0000_0000 / inv;
        return minv + 32'((pos * grid_step) >>> 16);
    endfunction

    task automatic random_queries(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                write_entry($urandom_range(0, STORE_DEPTH - 1), $urandom);
            else
                run_query(pick_coord(lookups.cfg_regs[CFG_DENSITY_MIN],
                                     lookups.cfg_regs[CFG_DENSITY_INV_STEP], N_RHO),
                          pick_coord(lookups.cfg_regs[CFG_TEMP_MIN],
                                     lookups.cfg_regs[CFG_TEMP_INV_STEP], N_TEMP),
                          pick_coord(lookups.cfg_regs[CFG_FRAC_MIN],
                                     lookups.cfg_regs[CFG_FRAC_INV_STEP], N_YE));
        end
    endtask

    initial
    begin
        lookups = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cycle_count = 0;
        burst_left = 0;
        stall_kind = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_QUERY;
        m_axis_tready = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = CFG_DENSITY_MIN;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_entry(0, 32'h7FFF_FFFF);
        write_entry(1, 32'h8000_0000);
        write_entry(STORE_DEPTH - 1, 32'h8000_0000);
        write_entry(STORE_DEPTH - 1, 32'h7FFF_FFFF);
        run_query(32'h0000_8000, 32'h0, 32'h0);
        run_query(32'h0000_FFFF, 32'h0, 32'h0);
        run_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        run_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        run_query(32'd63 << 16, 32'd63 << 16, 32'd31 << 16);
        run_query(32'h003E_FFFF, 32'h003E_FFFF, 32'h001E_FFFF);
        run_query(32'hFFFF_FFFF, 32'h0001_8000, 32'h0000_0001);
        run_query(32'h0020_5555, 32'hFFFF_0000, 32'h0010_AAAA);
        random_queries(60);

        load_grid(32'hFFFD_0000, 32'h0004_0000, 32'h0001_0000, 32'h0000_8000,
                  32'h0000_1234, 32'h0002_0000);
        random_queries(60);

        load_grid(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h1);
        run_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        run_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        random_queries(30);

        load_grid($urandom, $urandom_range(1, 32'h0010_0000), $urandom,
                  $urandom_range(1, 32'h0010_0000), $urandom, $urandom_range(1, 32'h0010_0000));
        random_queries(75);

        load_grid(32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000);
        random_queries(75);

        wait_idle();
        repeat (20) @(negedge clk);
        if (lookups.errors == 0 && lookups.value_fifo.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/tii_pkg.sv
hw/rtl/tii_ram.sv
hw/rtl/tii_axis.sv
hw/rtl/tii_lerp.sv
hw/rtl/trilinear_table_interpolator_core.sv
test/tb_trilinear_table_interpolator_core.sv
